// ----- sv/adagrad_weight_update_assert.svh -----
// ----------------------------------------------------------------------------
// AdaGrad weight update assertion macros
// Shared concurrent assertion forms used by the weight update block.
// ----------------------------------------------------------------------------
`ifndef ADAGRAD_WEIGHT_UPDATE_ASSERT_SVH
`define ADAGRAD_WEIGHT_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AWU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AWU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/awu_pkg.sv -----
// ----------------------------------------------------------------------------
// AdaGrad weight update package
// Field widths, bus types and register indexes of the weight update block.
// ----------------------------------------------------------------------------
package awu_pkg;

  localparam int IDX_W   = 12;
  localparam int DATA_W  = 16;
  localparam int ACC_W   = 40;
  localparam int SQRT_W  = 20;
  localparam int DEN_W   = 21;
  localparam int DIVR_W  = 25;
  localparam int QUO_W   = 27;
  localparam int PROD_W  = 32;
  localparam int STEP_W  = 29;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] SQRT_FIRST_BIT = ACC_W'(1) << (ACC_W - 2);

  localparam logic [DATA_W-1:0] LR_RESET  = 16'd655;
  localparam logic [DATA_W-1:0] EPS_RESET = 16'd1;

  typedef logic [47:0] s_tdata_t;
  typedef logic [31:0] m_tdata_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_index_t REG_STEP_SIZE = 2'd0;
  localparam cfg_index_t REG_EPSILON   = 2'd1;

endpackage

// ----- sv/adagrad_weight_update.sv -----
// ----------------------------------------------------------------------------
// AdaGrad weight update
// Applies one AdaGrad step per in-range item with a per-element accumulator.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ channel carries an element index, the
// current weight and its gradient. The element's accumulator in a local RAM
// adds the squared gradient, saturating at its maximum. The new weight is the
// old weight minus step size * gradient / (16 * (sqrt(accumulator) +
// epsilon)), saturated to 16 bits; the m_ channel returns index, weight and
// a clip flag. The cfg channel writes the step size (index 0) and epsilon
// (index 1) and is always ready; it is to be written only while the block is
// idle, which the block itself does not enforce. One multiplier, one 40-bit
// square root step and one divide step are reused by a sequencer. An in-range
// item with a nonzero denominator goes through RAM read and squaring,
// accumulate, 20 square root steps, divisor setup, 27 divide steps, sign and
// saturation and output load. The block takes a new item only once the last
// result is loaded. After reset the block clears all min(ELEMENTS, 4096)
// accumulator RAM entries, one entry a cycle, before s_tready rises. A
// stalled receiver holds the result in the output register; the block then
// takes one more item and waits with its result until the register frees up.
// ----------------------------------------------------------------------------
module adagrad_weight_update #(
  parameter int ELEMENTS = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // element_index[11:0], weight_in[27:12], grad_in[43:28], zero pad.
  input  awu_pkg::s_tdata_t     s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // element_out[11:0], weight_out[27:12], zero pad.
  output awu_pkg::m_tdata_t     m_tdata,
  // clipped[0].
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  awu_pkg::cfg_index_t   cfg_index,
  input  awu_pkg::cfg_data_t    cfg_data
);

  import awu_pkg::*;

  `include "adagrad_weight_update_assert.svh"

  localparam int MEM_DEPTH = (ELEMENTS < (1 << IDX_W)) ? ELEMENTS : (1 << IDX_W);
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_SQRT,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  state_t                    state;
  logic [AW-1:0]             clr_addr;
  logic [DATA_W-1:0]         step_size;
  logic [DATA_W-1:0]         epsilon;

  logic [IDX_W-1:0]          idx;
  logic signed [DATA_W-1:0]  w_reg;
  logic signed [DATA_W-1:0]  g_reg;
  logic signed [DATA_W-1:0]  res_w;
  logic                      clip;

  logic [ACC_W-1:0]          mem [MEM_DEPTH];
  logic [ACC_W-1:0]          rd_data;
  logic                      mem_we;
  logic [AW-1:0]             mem_addr;
  logic [ACC_W-1:0]          mem_wdata;

  logic [DATA_W-1:0]         mag_g;
  logic [DATA_W-1:0]         mul_a;
  logic [PROD_W-1:0]         mul_p;
  logic [PROD_W-1:0]         mul_q;

  logic [ACC_W:0]            acc_sum;
  logic [ACC_W-1:0]          acc_new;
  logic                      acc_sat;

  logic [ACC_W-1:0]          sq_rem;
  logic [ACC_W-1:0]          sq_res;
  logic [ACC_W-1:0]          sq_bit;
  logic [ACC_W:0]            sq_trial;
  logic                      sq_take;
  logic [ACC_W-1:0]          sq_rem_next;
  logic [ACC_W-1:0]          sq_res_next;

  logic [DEN_W-1:0]          denom;
  logic [DIVR_W-1:0]         divisor;
  logic [DIVR_W-1:0]         div_rem;
  logic [QUO_W-1:0]          div_quo;
  logic [4:0]                div_cnt;
  logic [DIVR_W:0]           div_trial;
  logic                      div_take;

  logic signed [STEP_W-1:0]  step_s;
  logic signed [STEP_W-1:0]  nw_wide;
  logic                      in_range;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_range  = {20'd0, s_tdata[IDX_W-1:0]} < 32'(ELEMENTS);

  assign mag_g = g_reg[DATA_W-1] ? DATA_W'(-g_reg) : DATA_W'(g_reg);
  assign mul_a = (state == ST_ACC) ? step_size : mag_g;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mag_g);

  assign acc_sum = {1'b0, rd_data} + (ACC_W + 1)'(mul_q);
  assign acc_sat = acc_sum[ACC_W];
  assign acc_new = acc_sat ? ACC_MAX : acc_sum[ACC_W-1:0];

  assign sq_trial    = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take     = {1'b0, sq_rem} >= sq_trial;
  assign sq_rem_next = sq_take ? (sq_rem - sq_trial[ACC_W-1:0]) : sq_rem;
  assign sq_res_next = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  assign denom = {1'b0, sq_res[SQRT_W-1:0]} + DEN_W'(epsilon);

  assign div_trial = {div_rem, mul_q[PROD_W-1]};
  assign div_take  = div_trial >= {1'b0, divisor};

  assign step_s  = STEP_W'(signed'({2'b00, div_quo}));
  assign nw_wide = g_reg[DATA_W-1] ? (STEP_W'(w_reg) + step_s) : (STEP_W'(w_reg) - step_s);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx[AW-1:0];
    mem_wdata = acc_new;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_ACC) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      m_tvalid  <= 1'b0;
      step_size <= LR_RESET;
      epsilon   <= EPS_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STEP_SIZE: step_size <= cfg_data;
          REG_EPSILON:   epsilon <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            idx   <= s_tdata[IDX_W-1:0];
            w_reg <= s_tdata[27:12];
            g_reg <= s_tdata[43:28];
            res_w <= s_tdata[27:12];
            clip  <= 1'b0;
            state <= in_range ? ST_READ : ST_DONE;
          end
        end
        ST_READ: begin
          mul_q <= mul_p;
          state <= ST_ACC;
        end
        ST_ACC: begin
          clip   <= acc_sat;
          mul_q  <= mul_p;
          sq_rem <= acc_new;
          sq_res <= '0;
          sq_bit <= SQRT_FIRST_BIT;
          state  <= ST_SQRT;
        end
        ST_SQRT: begin
          sq_rem <= sq_rem_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          divisor <= {denom, 4'b0000};
          div_rem <= DIVR_W'(mul_q[PROD_W-2:QUO_W]);
          mul_q   <= mul_q << (PROD_W - QUO_W);
          div_quo <= '0;
          div_cnt <= '0;
          state   <= (denom == '0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          div_rem <= div_take ? DIVR_W'(div_trial - {1'b0, divisor}) : div_trial[DIVR_W-1:0];
          div_quo <= {div_quo[QUO_W-2:0], div_take};
          mul_q   <= mul_q << 1;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(QUO_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (nw_wide > STEP_W'(32767)) begin
            res_w <= 16'sh7fff;
            clip  <= 1'b1;
          end else if (nw_wide < -STEP_W'(32768)) begin
            res_w <= 16'sh8000;
            clip  <= 1'b1;
          end else begin
            res_w <= nw_wide[DATA_W-1:0];
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'b0000, res_w, idx};
            m_tuser  <= clip;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AWU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
    "input accepted while an item is still in progress")
  `AWU_ASSERT_NOW(a_sqrt_bit_onehot, state == ST_SQRT, $onehot(sq_bit),
    "square root step bit lost its single set bit")
  `AWU_ASSERT_NOW(a_div_rem_bound, state == ST_DIV, div_rem < divisor,
    "divider remainder not below divisor")
  `AWU_ASSERT_NEXT(a_result_held, (state == ST_DONE) && m_tvalid && !m_tready,
    state == ST_DONE, "pending result overwritten while receiver stalls")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// AdaGrad weight update testbench
// Streams weight and gradient transactions through the block and checks every
// result against a cycle-free model of the update that keeps its own
// per-element accumulators and register copies. Directed transactions cover
// the field extremes, saturation of the weight, a zero denominator and writes
// to unmapped registers. Random phases follow under several register
// settings and idling patterns. Each phase also drives a single element with
// full-scale gradients, so that its accumulator saturates in the last phase.
// Early in the run the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import awu_pkg::*;

  localparam int ELEMENTS         = 4096;
  localparam int HOLD_AT          = 120;
  localparam int HOLD_CYCLES      = 600;
  localparam int DRAIN_PAUSE      = 64;
  localparam int IDLE_LIMIT       = 20000;
  localparam int RANDOM_PER_PHASE = 12;
  localparam int HAMMER_PER_PHASE = 258;
  localparam int HAMMER_INDEX     = 4000;
  localparam int REPORT_LINES     = 50;

  localparam cfg_index_t REG_UNMAPPED_LO = 2'd2;
  localparam cfg_index_t REG_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] weight;
    logic [IDX_W-1:0]         element;
  } weight_update_t;

  typedef struct packed {
    logic [IDX_W-1:0]  element;
    logic [DATA_W-1:0] weight;
    logic              clipped;
  } updated_weight_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  s_tdata_t   s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  m_tdata_t   m_tdata;
  logic       m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = REG_STEP_SIZE;
  cfg_data_t  cfg_data = '0;

  weight_update_t    pending_updates[$];
  updated_weight_t   expected_weights[$];
  logic [ACC_W-1:0]  grad_energy [ELEMENTS] = '{default: '0};
  logic [DATA_W-1:0] step_rate = LR_RESET;
  logic [DATA_W-1:0] step_epsilon = EPS_RESET;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   accepted_updates = 0;
  int   mismatch_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;
  logic in_took = 1'b0;

  adagrad_weight_update #(.ELEMENTS(ELEMENTS)) dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [SQRT_W-1:0] floor_sqrt(logic [ACC_W-1:0] x);
    logic [SQRT_W-1:0] root;
    logic [SQRT_W-1:0] trial;
    longint unsigned   t;
    root = '0;
    for (int b = SQRT_W - 1; b >= 0; b--) begin
      trial = root | (SQRT_W'(1) << b);
      t = trial;
      if (t * t <= x) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic updated_weight_t apply_adagrad_step(weight_update_t u);
    updated_weight_t r;
    longint          gs;
    longint          nw;
    longint unsigned mag;
    longint unsigned acc;
    longint unsigned den;
    longint unsigned num;
    longint unsigned step;
    gs = $signed(u.grad);
    nw = $signed(u.weight);
    r.clipped = 1'b0;
    if (u.element < ELEMENTS) begin
      mag = (gs < 0) ? -gs : gs;
      acc = grad_energy[u.element];
      if (acc + mag * mag > ACC_MAX) begin
        acc = ACC_MAX;
        r.clipped = 1'b1;
      end else begin
        acc = acc + mag * mag;
      end
      grad_energy[u.element] = ACC_W'(acc);
      den = floor_sqrt(ACC_W'(acc));
      den = den + step_epsilon;
      if (den != 0) begin
        num = mag * step_rate;
        step = num / (den * 16);
        nw = (gs < 0) ? nw + longint'(step) : nw - longint'(step);
        if (nw > 32767) begin
          nw = 32767;
          r.clipped = 1'b1;
        end else if (nw < -32768) begin
          nw = -32768;
          r.clipped = 1'b1;
        end
      end
    end
    r.element = u.element;
    r.weight = DATA_W'(nw);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < REPORT_LINES) begin
      $display("MISMATCH at %0t: %s got %0h, want %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    updated_weight_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_weights.push_back(apply_adagrad_step(s_tdata[IDX_W+2*DATA_W-1:0]));
        accepted_updates <= accepted_updates + 1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_weights.size() == 0) begin
          report_mismatch("result with none pending", m_tdata, 0);
        end else begin
          want = expected_weights.pop_front();
          if (m_tdata[IDX_W-1:0] !== want.element) begin
            report_mismatch("element_out", m_tdata[IDX_W-1:0], want.element);
          end
          if (m_tdata[IDX_W+DATA_W-1:IDX_W] !== want.weight) begin
            report_mismatch("weight_out", m_tdata[IDX_W+DATA_W-1:IDX_W], want.weight);
          end
          if (m_tuser !== want.clipped) begin
            report_mismatch("clipped", m_tuser, want.clipped);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE: step_rate <= cfg_data;
          REG_EPSILON: step_epsilon <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (pending_updates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, pending_updates.pop_front()};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && !hold_done && accepted_updates >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_update(int element, int weight, int grad);
    weight_update_t u;
    u.element = IDX_W'(element);
    u.weight = DATA_W'(weight);
    u.grad = DATA_W'(grad);
    pending_updates.push_back(u);
  endtask

  task automatic write_register(cfg_index_t index, cfg_data_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_updates.size() != 0 || s_tvalid || expected_weights.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_q312();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic weight_update_t random_update();
    weight_update_t u;
    u.element = ($urandom_range(1) == 0) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
    u.weight = random_q312();
    u.grad = random_q312();
    return u;
  endfunction

  function automatic weight_update_t hammer_update();
    weight_update_t u;
    u.element = IDX_W'(HAMMER_INDEX);
    u.weight = random_q312();
    u.grad = ($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF;
    return u;
  endfunction

  function automatic cfg_data_t random_setting();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    queue_update(0, 0, 0);
    queue_update(4095, 32767, -32768);
    queue_update(1, -32768, 32767);
    queue_update(2, 1234, 1);
    queue_update(2, -1, -1);
    wait_drained();

    write_register(REG_STEP_SIZE, 16'hFFFF);
    write_register(REG_EPSILON, 16'h0000);
    write_register(REG_UNMAPPED_LO, 16'($urandom));
    write_register(REG_UNMAPPED_HI, 16'($urandom));
    queue_update(10, 5000, 0);
    queue_update(11, 0, 1);
    queue_update(12, 32767, -32768);
    queue_update(13, -32768, 32767);
    queue_update(14, 21555, -23131);
    wait_drained();

    write_register(REG_STEP_SIZE, 16'h0000);
    write_register(REG_EPSILON, 16'hFFFF);
    queue_update(20, 100, 32767);
    queue_update(21, -100, -32768);
    queue_update(10, 7, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      write_register(REG_STEP_SIZE, random_setting());
      write_register(REG_EPSILON, random_setting());
      repeat (RANDOM_PER_PHASE) pending_updates.push_back(random_update());
      repeat (HAMMER_PER_PHASE) pending_updates.push_back(hammer_update());
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
